/* rtl/bde_pkg.sv */
// Package for the block diff encoder: constants, payload types and result helpers.
`timescale 1ns / 1ps
`default_nettype none

package bde_pkg;

  // Widths of the block index, addresses, words and the run counter.
  localparam int IndexBits = 32;
  localparam int FromW     = 32;
  localparam int AddrW     = 33;
  localparam int WordW     = 64;
  localparam int RunW      = 17;
  localparam int WindowW   = 16;
  localparam int StartW    = 32;
  localparam int CfgDataW  = 32;
  localparam int SumW      = IndexBits + RunW;

  // Up to four results follow from one word pair.
  localparam int SlotCount = 4;
  localparam int CountW    = 3;

  localparam logic [WindowW-1:0] WindowReset = WindowW'(128);
  localparam logic [RunW-1:0]    RunMax      = {RunW{1'b1}};

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_DONE   = 2'd2
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_START_BLOCK = 1'b0,
    CFG_GAP_WINDOW  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [WordW-1:0] new_word;
    logic [WordW-1:0] old_word;
    logic             final_block;
  } in_t;

  typedef struct packed {
    kind_e            kind;
    logic [AddrW-1:0] address;
    logic [WordW-1:0] word_value;
    logic [AddrW-1:0] diff_length;
    logic             last_of_run;
  } out_t;

  // Results of one word pair, in order, with their number.
  typedef struct packed {
    out_t [SlotCount-1:0] res;
    logic [CountW-1:0]    count;
  } bundle_t;

  // A data or header write.
  function automatic out_t make_write(kind_e kind, logic [AddrW-1:0] addr,
                                      logic [WordW-1:0] value);
    out_t r;
    r.kind        = kind;
    r.address     = addr;
    r.word_value  = value;
    r.diff_length = '0;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // The closing word that reports the diff length.
  function automatic out_t make_done(logic [AddrW-1:0] len);
    out_t r;
    r.kind        = KIND_DONE;
    r.address     = '0;
    r.word_value  = '0;
    r.diff_length = len;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Header word: from in the upper half, to in the lower half.
  function automatic logic [WordW-1:0] header_word(logic [IndexBits-1:0] from,
                                                   logic [IndexBits-1:0] to);
    return {FromW'(from), FromW'(to)};
  endfunction

endpackage

`default_nettype wire

/* rtl/bde_core.sv */
// Segment state of the diff encoder and the results built for each accepted word pair.
`timescale 1ns / 1ps
`default_nettype none

module bde_core
  import bde_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  in_t                  in_data_i,
  input  logic [StartW-1:0]    start_block_i,
  input  logic [WindowW-1:0]   gap_window_i,
  output bundle_t              bundle_o
);

  logic                 range_open_q, range_open_d;
  logic                 skip_q, skip_d;
  logic [AddrW-1:0]     cursor_q, cursor_d;
  logic [AddrW-1:0]     hdr_addr_q, hdr_addr_d;
  logic [IndexBits-1:0] from_q, from_d;
  logic [RunW-1:0]      run_q, run_d;
  logic [IndexBits-1:0] index_q, index_d;

  // State as seen by this word pair: a new range starts from fresh values.
  logic                 skip_e;
  logic [AddrW-1:0]     cursor_e, hdr_addr_e;
  logic [IndexBits-1:0] from_e, idx;
  logic [RunW-1:0]      run_e, run_inc;

  // State after the compare step, before the range end is handled.
  logic                 skip_1;
  logic [AddrW-1:0]     cursor_1, hdr_addr_1;
  logic [IndexBits-1:0] from_1;
  logic [RunW-1:0]      run_1, back;
  logic [IndexBits-1:0] to_close, to_final;
  logic [AddrW-1:0]     cursor_2;
  logic                 differ;

  out_t [1:0]           first, tail;
  logic [1:0]           n1, n2;
  bundle_t              bundle;

  always_comb begin
    if (range_open_q) begin
      skip_e     = skip_q;
      cursor_e   = cursor_q;
      hdr_addr_e = hdr_addr_q;
      from_e     = from_q;
      run_e      = run_q;
      idx        = index_q;
    end else begin
      skip_e     = 1'b1;
      cursor_e   = '0;
      hdr_addr_e = '0;
      from_e     = '0;
      run_e      = '0;
      idx        = start_block_i[IndexBits-1:0];
    end
  end

  assign differ  = in_data_i.new_word != in_data_i.old_word;
  assign run_inc = (run_e == RunMax) ? run_e : run_e + RunW'(1);

  // Compare step: open a segment, extend it, or close it on a long equal run.
  always_comb begin
    skip_1     = skip_e;
    cursor_1   = cursor_e;
    hdr_addr_1 = hdr_addr_e;
    from_1     = from_e;
    run_1      = run_e;
    back       = '0;
    to_close   = '0;
    first[0]   = make_done('0);
    first[1]   = make_done('0);
    n1         = 2'd0;
    if (skip_e) begin
      if (differ) begin
        skip_1     = 1'b0;
        hdr_addr_1 = cursor_e;
        from_1     = idx;
        run_1      = '0;
        first[0]   = make_write(KIND_HEADER, cursor_e, header_word(idx, '0));
        first[1]   = make_write(KIND_DATA, cursor_e + AddrW'(1), in_data_i.new_word);
        cursor_1   = cursor_e + AddrW'(2);
        n1         = 2'd2;
      end else begin
        run_1 = run_inc;
      end
    end else begin
      run_1 = differ ? '0 : run_inc;
      if (run_1 > RunW'(gap_window_i)) begin
        back     = run_1 - RunW'(1);
        to_close = idx - IndexBits'(back);
        skip_1   = 1'b1;
        cursor_1 = cursor_e - AddrW'(back);
        first[0] = make_write(KIND_HEADER, hdr_addr_e, header_word(from_e, to_close));
      end else begin
        first[0] = make_write(KIND_DATA, cursor_e, in_data_i.new_word);
        cursor_1 = cursor_e + AddrW'(1);
      end
      n1 = 2'd1;
    end
  end

  // Range end: close an open segment and report the length.
  always_comb begin
    to_final = idx + IndexBits'(1) - IndexBits'(run_1);
    cursor_2 = cursor_1;
    tail[0]  = make_done('0);
    tail[1]  = make_done('0);
    n2       = 2'd0;
    if (in_data_i.final_block) begin
      if (!skip_1) begin
        cursor_2 = cursor_1 - AddrW'(run_1);
        tail[0]  = make_write(KIND_HEADER, hdr_addr_1, header_word(from_1, to_final));
        tail[1]  = make_done(cursor_2);
        n2       = 2'd2;
      end else begin
        tail[0] = make_done(cursor_2);
        n2      = 2'd1;
      end
    end
  end

  // Pack both groups into consecutive slots and mark the last one.
  always_comb begin
    bundle.res   = '0;
    bundle.count = CountW'(n1) + CountW'(n2);
    case (n1)
      2'd0: begin
        bundle.res[0] = tail[0];
        bundle.res[1] = tail[1];
      end
      2'd1: begin
        bundle.res[0] = first[0];
        bundle.res[1] = tail[0];
        bundle.res[2] = tail[1];
      end
      2'd2: begin
        bundle.res[0] = first[0];
        bundle.res[1] = first[1];
        bundle.res[2] = tail[0];
        bundle.res[3] = tail[1];
      end
      default: begin
        bundle.res = '0;
      end
    endcase
    for (int k = 0; k < SlotCount; k++) begin
      bundle.res[k].last_of_run = (CountW'(k + 1) == bundle.count);
    end
  end

  assign bundle_o = bundle;

  // Next state, taken only when a word pair is accepted.
  always_comb begin
    range_open_d = !in_data_i.final_block;
    skip_d       = skip_1 || in_data_i.final_block;
    cursor_d     = cursor_2;
    hdr_addr_d   = hdr_addr_1;
    from_d       = from_1;
    run_d        = run_1;
    index_d      = idx + IndexBits'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_open_q <= 1'b0;
      skip_q       <= 1'b1;
      cursor_q     <= '0;
      hdr_addr_q   <= '0;
      from_q       <= '0;
      run_q        <= '0;
      index_q      <= '0;
    end else if (accept_i) begin
      range_open_q <= range_open_d;
      skip_q       <= skip_d;
      cursor_q     <= cursor_d;
      hdr_addr_q   <= hdr_addr_d;
      from_q       <= from_d;
      run_q        <= run_d;
      index_q      <= index_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/block_diff_encoder_top.sv */
// Top level of the block diff encoder: configuration registers, core and result buffer.
//
//   Channel  Direction  Handshake                 Word
//   in       input      in_valid_i / in_ready_o   in_data_i (new, old, final flag)
//   out      output     out_valid_o / out_ready_i out_data_o (kind, address, value, length)
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A word pair is processed in the cycle it is accepted; its results land in a
// four-slot buffer and leave one per cycle while out_ready_i is high. A pair
// gives up to four results and the input is taken while the last buffered word
// is read out, so plain data streams one pair per cycle while out_ready_i is high.
// Reset clears the segment state and the buffer; gap_window resets to 128.
`timescale 1ns / 1ps
`default_nettype none

module block_diff_encoder_top
  import bde_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  cfg_reg_e            cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [StartW-1:0]     start_block_q;
  logic [WindowW-1:0]    gap_window_q;
  out_t [SlotCount-1:0]  slots_q;
  logic [CountW-1:0]     remain_q;
  logic                  accept, pop;
  bundle_t               bundle;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_block_q <= '0;
      gap_window_q  <= WindowReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START_BLOCK: start_block_q <= cfg_data_i[StartW-1:0];
        CFG_GAP_WINDOW:  gap_window_q  <= cfg_data_i[WindowW-1:0];
        default:         start_block_q <= start_block_q;
      endcase
    end
  end

  // Handshakes: the input waits until the buffer is empty or draining its last word.
  assign out_valid_o = remain_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign in_ready_o  = (remain_q == '0) || (remain_q == CountW'(1) && out_ready_i);
  assign accept      = in_valid_i && in_ready_o;

  bde_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_data_i     (in_data_i),
    .start_block_i (start_block_q),
    .gap_window_i  (gap_window_q),
    .bundle_o      (bundle)
  );

  // Result buffer: loaded whole on accept, shifted down as words leave.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
    end else if (accept) begin
      remain_q <= bundle.count;
    end else if (pop) begin
      remain_q <= remain_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slots_q <= bundle.res;
    end else if (pop) begin
      for (int k = 0; k < SlotCount - 1; k++) begin
        slots_q[k] <= slots_q[k + 1];
      end
    end
  end

  assign out_data_o = slots_q[0];

endmodule

`default_nettype wire

/* rtl/bde_checker.sv */
// Port checker for the block diff encoder and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bde_checker
  import bde_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_o,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  out_t                out_data_o
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // The input only stalls while results are waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // The length report always closes the results of its word pair.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_DONE |-> out_data_o.last_of_run)
    else $error("length report not last of its pair");

  // A word not last of its pair is never the last word waiting, and no new pair
  // is taken while it leaves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_of_run |-> !(in_valid_i && in_ready_o)
    ##1 out_valid_o)
    else $error("results of one pair were split");

endmodule

bind block_diff_encoder_top bde_checker u_bde_checker (.*);

`default_nettype wire
